### rtl/core/sbm_pkg.sv
// Shared types, codes and the CRC16-CCITT byte step for the serial bus master.
package sbm_pkg;

  // Item kinds on the input side
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_BYTE = 2'd1;
  localparam logic [1:0] FN_SEND = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TX     = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  // Bus phase codes as shown on the result ports
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SENDING = 3'd1;
  localparam logic [2:0] PH_AWAIT   = 3'd2;
  localparam logic [2:0] PH_RECV    = 3'd3;
  localparam logic [2:0] PH_RECOVER = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_START_TO   = 3'd2;
  localparam logic [2:0] ERR_BYTE_TO    = 3'd3;
  localparam logic [2:0] ERR_BAD_START  = 3'd4;
  localparam logic [2:0] ERR_ID         = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd6;
  localparam logic [2:0] ERR_CRC        = 3'd7;

  // Configuration register indexes and reset values
  localparam int          CFG_INDEX_W    = 8;
  localparam logic [7:0]  REG_RECOVERY   = 8'd0;
  localparam logic [7:0]  REG_START_TO   = 8'd1;
  localparam logic [7:0]  REG_BYTE_TO    = 8'd2;
  localparam logic [7:0]  REG_END_WAIT   = 8'd3;
  localparam logic [15:0] RECOVERY_RST   = 16'd10000;
  localparam logic [15:0] START_TO_RST   = 16'd1000;
  localparam logic [15:0] BYTE_TO_RST    = 16'd1000;
  localparam logic [15:0] END_WAIT_RST   = 16'd500;

  // Framing
  localparam logic [7:0]  START_MARK = 8'h21;  // '!'
  localparam logic [7:0]  ACK_MARK   = 8'h24;  // '$'
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [3:0]  REPLY_LEN  = 4'd8;
  localparam logic [3:0]  CRC_BYTES  = 4'd6;
  localparam logic [3:0]  FRAME_LAST = 4'd8;

  // Queue depths
  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_SEND,
    JOB_REPLY
  } job_kind_t;

  // One classified item handed from front to back
  typedef struct packed {
    job_kind_t   kind;
    logic        accepted;
    logic [2:0]  err;
    logic [2:0]  phase;
    logic [7:0]  a;     // message id (send) or module (reply)
    logic [7:0]  b;     // command byte
    logic [31:0] w;     // request parameter or reply value
  } job_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        accepted;
    logic [2:0]  error_code;
    logic [2:0]  bus_phase;
    logic [7:0]  reply_module;
    logic [7:0]  reply_command;
    logic [31:0] reply_value;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] x;
    x = crc[15:8] ^ data;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

### rtl/core/serial_bus_master_request_reply.sv
// Master side of a half-duplex request/reply serial bus. Input items are a
// one millisecond tick, a received bus byte or a send request; each is taken
// on push while full is low, and a new item may follow in every cycle while
// full stays low. A front end runs the bus phase machine, the timers and
// reply capture and turns every item into one job in a two-entry queue; a
// back end turns each job into result items for a two-entry result queue
// whose head sits on the result ports, one per cycle while that queue has
// room. Ticks, bytes, refused requests and delivered replies give one result
// each; an accepted request gives nine transmit bytes ('!', id, command,
// parameter LSB first, CRC16-CCITT low then high). The back end holds an
// accepted request until its ninth byte has left; the job queue takes one
// more item behind it and then holds full until the ninth byte has left, so
// the input stalls after each accepted request even while results are taken
// as they come; other items then run at one per cycle. The first result of
// an item is registered in the job queue and then in the result queue. The
// reply CRC is accumulated as reply bytes arrive. Configuration writes are
// always ready and take effect on the next cycle; indexes past the last
// register are ignored. There is no clearing pass after reset.
module serial_bus_master_request_reply #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func,
  input  logic [7:0]                      rx_byte,
  input  logic [7:0]                      target_module,
  input  logic [7:0]                      message_id,
  input  logic [7:0]                      command,
  input  logic [31:0]                     parameter_req,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      kind,
  output logic [7:0]                      tx_byte,
  output logic                            last,
  output logic                            accepted,
  output logic [2:0]                      error_code,
  output logic [2:0]                      bus_phase,
  output logic [7:0]                      reply_module,
  output logic [7:0]                      reply_command,
  output logic [31:0]                     reply_value,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import sbm_pkg::*;

  logic accept;
  job_t job_in, job_head;
  logic job_empty, job_pop;
  res_t res_in, res_head;
  logic res_push, res_full;

  // Take a request whenever the job queue has room.
  assign accept    = push & ~full;
  assign cfg_ready = 1'b1;

  sbm_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .func          (func),
    .rx_byte       (rx_byte),
    .target_module (target_module),
    .message_id    (message_id),
    .command       (command),
    .parameter_req (parameter_req),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .job           (job_in)
  );

  // Hold classified jobs so the front keeps accepting while the back sends.
  sbm_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  sbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (~job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Hold finished results until the consumer drains them.
  sbm_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign kind          = res_head.kind;
  assign tx_byte       = res_head.tx_byte;
  assign last          = res_head.last;
  assign accepted      = res_head.accepted;
  assign error_code    = res_head.error_code;
  assign bus_phase     = res_head.bus_phase;
  assign reply_module  = res_head.reply_module;
  assign reply_command = res_head.reply_command;
  assign reply_value   = res_head.reply_value;

endmodule

### rtl/core/sbm_queue.sv
// Small first-in first-out queue with push/full and pop/empty.
module sbm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

### rtl/core/sbm_front.sv
// Front end: bus phase machine, timers, reply capture and item classification.
module sbm_front #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [1:0]                      func,
  input  logic [7:0]                      rx_byte,
  input  logic [7:0]                      target_module,
  input  logic [7:0]                      message_id,
  input  logic [7:0]                      command,
  input  logic [31:0]                     parameter_req,
  input  logic                            cfg_we,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output sbm_pkg::job_t                   job
);
  import sbm_pkg::*;

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  typedef enum logic [2:0] {
    S_IDLE    = PH_IDLE,
    S_SENDING = PH_SENDING,
    S_AWAIT   = PH_AWAIT,
    S_RECV    = PH_RECV,
    S_RECOVER = PH_RECOVER
  } phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             err, err_next;
  logic [TIMER_WIDTH-1:0] elapsed, elapsed_next, el_inc;
  logic [3:0]             count, count_next;
  logic [15:0]            crc_run, crc_run_next;
  logic [7:0]             sent_id, sent_id_next;
  logic [7:0]             pend_mod, pend_mod_next;
  logic [15:0]            recovery_ms, start_to_ms, byte_to_ms, end_wait_ms;
  logic [7:0]             store [8];
  logic                   store_we;
  logic                   over_recovery, over_start, over_byte, over_end;

  assign el_inc = (elapsed == '1) ? elapsed : elapsed + TIMER_WIDTH'(1);
  assign over_recovery = CW'(el_inc) > CW'(recovery_ms);
  assign over_start    = CW'(el_inc) > CW'(start_to_ms);
  assign over_byte     = CW'(el_inc) > CW'(byte_to_ms);
  assign over_end      = CW'(el_inc) > CW'(end_wait_ms);

  always_comb begin
    phase_next    = phase;
    err_next      = err;
    elapsed_next  = elapsed;
    count_next    = count;
    crc_run_next  = crc_run;
    sent_id_next  = sent_id;
    pend_mod_next = pend_mod;
    store_we      = 1'b0;
    job.kind      = JOB_STATUS;
    job.accepted  = 1'b0;
    job.a         = '0;
    job.b         = '0;
    job.w         = '0;
    if (in_valid) begin
      case (func)
        FN_SEND: begin
          if (phase == S_IDLE) begin
            pend_mod_next = target_module;
            sent_id_next  = message_id;
            phase_next    = S_AWAIT;
            elapsed_next  = '0;
            count_next    = '0;
            job.kind      = JOB_SEND;
            job.accepted  = 1'b1;
            job.a         = message_id;
            job.b         = command;
            job.w         = parameter_req;
          end
        end
        FN_BYTE: begin
          case (phase)
            S_RECOVER: elapsed_next = '0;
            S_AWAIT: begin
              elapsed_next = '0;
              if (rx_byte != ACK_MARK) begin
                err_next   = ERR_BAD_START;
                phase_next = S_RECOVER;
              end else begin
                count_next   = '0;
                crc_run_next = CRC_INIT;
                phase_next   = S_RECV;
              end
            end
            S_RECV: begin
              elapsed_next = '0;
              if (count >= REPLY_LEN) begin
                err_next   = ERR_TOO_LONG;
                phase_next = S_RECOVER;
              end else begin
                store_we   = 1'b1;
                count_next = count + 4'd1;
                if (count < CRC_BYTES) crc_run_next = crc_step(crc_run, rx_byte);
              end
            end
            default: begin
              elapsed_next = '0;
              err_next     = ERR_UNEXPECTED;
              phase_next   = S_RECOVER;
            end
          endcase
        end
        FN_TICK: begin
          elapsed_next = el_inc;
          case (phase)
            S_RECOVER: begin
              if (over_recovery) begin
                phase_next   = S_IDLE;
                elapsed_next = '0;
              end
            end
            S_AWAIT: begin
              if (over_start) begin
                err_next     = ERR_START_TO;
                phase_next   = S_RECOVER;
                elapsed_next = '0;
              end
            end
            S_RECV: begin
              if (count == REPLY_LEN) begin
                if (over_end) begin
                  elapsed_next = '0;
                  if (store[6] != crc_run[7:0] || store[7] != crc_run[15:8]) begin
                    err_next   = ERR_CRC;
                    phase_next = S_RECOVER;
                  end else if (store[0] != sent_id) begin
                    err_next   = ERR_ID;
                    phase_next = S_RECOVER;
                  end else begin
                    phase_next = S_IDLE;
                    job.kind   = JOB_REPLY;
                    job.a      = pend_mod;
                    job.b      = store[1];
                    job.w      = {store[5], store[4], store[3], store[2]};
                  end
                end
              end else if (over_byte) begin
                err_next     = ERR_BYTE_TO;
                phase_next   = S_RECOVER;
                elapsed_next = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    job.err   = err_next;
    job.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= S_IDLE;
      err         <= ERR_NONE;
      elapsed     <= '0;
      count       <= '0;
      crc_run     <= CRC_INIT;
      sent_id     <= '0;
      pend_mod    <= '0;
      recovery_ms <= RECOVERY_RST;
      start_to_ms <= START_TO_RST;
      byte_to_ms  <= BYTE_TO_RST;
      end_wait_ms <= END_WAIT_RST;
    end else begin
      phase    <= phase_next;
      err      <= err_next;
      elapsed  <= elapsed_next;
      count    <= count_next;
      crc_run  <= crc_run_next;
      sent_id  <= sent_id_next;
      pend_mod <= pend_mod_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_RECOVERY: recovery_ms <= cfg_data;
          REG_START_TO: start_to_ms <= cfg_data;
          REG_BYTE_TO:  byte_to_ms  <= cfg_data;
          REG_END_WAIT: end_wait_ms <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store[count[2:0]] <= rx_byte;
  end

endmodule

### rtl/core/sbm_back.sv
// Back end: expand each job into result items, framing and CRC for requests.
module sbm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  sbm_pkg::job_t job,
  output logic          job_pop,
  output logic          res_push,
  output sbm_pkg::res_t res,
  input  logic          res_full
);
  import sbm_pkg::*;

  logic [3:0]  idx;
  logic [15:0] crc;
  logic [7:0]  frame_byte;
  logic        emit;
  logic        is_send;

  assign is_send  = (job.kind == JOB_SEND);
  assign emit     = job_valid & ~res_full;
  assign res_push = emit;
  assign job_pop  = emit & (~is_send | (idx == FRAME_LAST));

  always_comb begin
    case (idx)
      4'd0:    frame_byte = START_MARK;
      4'd1:    frame_byte = job.a;
      4'd2:    frame_byte = job.b;
      4'd3:    frame_byte = job.w[7:0];
      4'd4:    frame_byte = job.w[15:8];
      4'd5:    frame_byte = job.w[23:16];
      4'd6:    frame_byte = job.w[31:24];
      4'd7:    frame_byte = crc[7:0];
      4'd8:    frame_byte = crc[15:8];
      default: frame_byte = '0;
    endcase
  end

  always_comb begin
    res.error_code    = job.err;
    res.accepted      = job.accepted;
    res.tx_byte       = '0;
    res.reply_module  = '0;
    res.reply_command = '0;
    res.reply_value   = '0;
    res.last          = 1'b1;
    res.bus_phase     = job.phase;
    case (job.kind)
      JOB_SEND: begin
        res.kind      = KIND_TX;
        res.tx_byte   = frame_byte;
        res.last      = (idx == FRAME_LAST);
        res.bus_phase = (idx == FRAME_LAST) ? PH_AWAIT : PH_SENDING;
      end
      JOB_REPLY: begin
        res.kind          = KIND_REPLY;
        res.reply_module  = job.a;
        res.reply_command = job.b;
        res.reply_value   = job.w;
      end
      default: res.kind = KIND_STATUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= CRC_INIT;
    end else if (emit && is_send) begin
      if (idx == FRAME_LAST) begin
        idx <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
      if (idx == 4'd0) begin
        crc <= CRC_INIT;
      end else if (idx <= CRC_BYTES) begin
        crc <= crc_step(crc, frame_byte);
      end
    end
  end

endmodule

### bench/sbm_bench_pkg.sv
// Bus item type, CRC helper and the request/reply scoreboard for the serial bus master bench.
package sbm_bench_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;

  localparam logic [1:0]  FN_UNUSED  = 2'd3;
  localparam logic [15:0] CCITT_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [7:0]  target_module;
    logic [7:0]  message_id;
    logic [7:0]  command;
    logic [31:0] parameter_req;
  } bus_item_t;

  // Bitwise CRC16-CCITT over six bytes, first byte in bits 7:0
  function automatic logic [15:0] crc_ccitt16(logic [47:0] bytes6);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc ^= {bytes6[8*i +: 8], 8'h00};
      for (int k = 0; k < 8; k++) crc = crc[15] ? ((crc << 1) ^ CCITT_POLY) : (crc << 1);
    end
    return crc;
  endfunction

  class bus_master_scoreboard;
    logic [15:0] recovery_ms, start_limit, gap_limit, end_wait;
    logic [2:0]  phase, last_err;
    logic [15:0] elapsed;
    int unsigned reply_cnt;
    logic [7:0]  reply_buf [8];
    logic [7:0]  sent_id, target;
    res_t        results_due [$];
    int unsigned mismatches;

    function new();
      recovery_ms = RECOVERY_RST;
      start_limit = START_TO_RST;
      gap_limit   = BYTE_TO_RST;
      end_wait    = END_WAIT_RST;
      phase       = PH_IDLE;
      last_err    = ERR_NONE;
      elapsed     = '0;
      reply_cnt   = 0;
      sent_id     = '0;
      target      = '0;
      mismatches  = 0;
      foreach (reply_buf[i]) reply_buf[i] = '0;
    endfunction

    function void write_register(logic [7:0] idx, logic [15:0] val);
      case (idx)
        REG_RECOVERY: recovery_ms = val;
        REG_START_TO: start_limit = val;
        REG_BYTE_TO:  gap_limit = val;
        REG_END_WAIT: end_wait = val;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction

    function void emit(logic [1:0] k, logic [7:0] tx, logic lst, logic acc, logic [2:0] ph,
                       logic [7:0] mod, logic [7:0] cmd, logic [31:0] val);
      res_t r;
      r.kind          = k;
      r.tx_byte       = tx;
      r.last          = lst;
      r.accepted      = acc;
      r.error_code    = last_err;
      r.bus_phase     = ph;
      r.reply_module  = mod;
      r.reply_command = cmd;
      r.reply_value   = val;
      results_due.push_back(r);
    endfunction

    function void enter_phase(logic [2:0] p);
      phase   = p;
      elapsed = '0;
    endfunction

    function void set_fault(logic [2:0] code);
      last_err = code;
      enter_phase(PH_RECOVER);
    endfunction

    // Advance the bus state by one accepted request and queue what it must produce
    function void take_request(bus_item_t it);
      logic [47:0] body;
      logic [15:0] crc;
      case (it.func)
        FN_SEND: begin
          if (phase != PH_IDLE) begin
            emit(KIND_STATUS, '0, 1'b1, 1'b0, phase, '0, '0, '0);
            return;
          end
          target  = it.target_module;
          sent_id = it.message_id;
          body    = {it.parameter_req, it.command, it.message_id};
          crc     = crc_ccitt16(body);
          enter_phase(PH_AWAIT);
          reply_cnt = 0;
          emit(KIND_TX, START_MARK, 1'b0, 1'b1, PH_SENDING, '0, '0, '0);
          for (int i = 0; i < 6; i++)
            emit(KIND_TX, body[8*i +: 8], 1'b0, 1'b1, PH_SENDING, '0, '0, '0);
          emit(KIND_TX, crc[7:0], 1'b0, 1'b1, PH_SENDING, '0, '0, '0);
          emit(KIND_TX, crc[15:8], 1'b1, 1'b1, PH_AWAIT, '0, '0, '0);
          return;
        end
        FN_BYTE: begin
          case (phase)
            PH_RECOVER: enter_phase(PH_RECOVER);
            PH_AWAIT: begin
              if (it.rx_byte != ACK_MARK) set_fault(ERR_BAD_START);
              else begin
                reply_cnt = 0;
                enter_phase(PH_RECV);
              end
            end
            PH_RECV: begin
              if (reply_cnt >= REPLY_LEN) set_fault(ERR_TOO_LONG);
              else begin
                reply_buf[reply_cnt] = it.rx_byte;
                reply_cnt++;
                enter_phase(PH_RECV);
              end
            end
            default: set_fault(ERR_UNEXPECTED);
          endcase
        end
        FN_TICK: begin
          if (elapsed != '1) elapsed++;
          case (phase)
            PH_RECOVER: if (elapsed > recovery_ms) enter_phase(PH_IDLE);
            PH_AWAIT:   if (elapsed > start_limit) set_fault(ERR_START_TO);
            PH_RECV: begin
              if (reply_cnt == REPLY_LEN) begin
                if (elapsed > end_wait) begin
                  body = {reply_buf[5], reply_buf[4], reply_buf[3],
                          reply_buf[2], reply_buf[1], reply_buf[0]};
                  crc = crc_ccitt16(body);
                  enter_phase(PH_IDLE);
                  if ({reply_buf[7], reply_buf[6]} != crc) set_fault(ERR_CRC);
                  else if (reply_buf[0] != sent_id) set_fault(ERR_ID);
                  else begin
                    emit(KIND_REPLY, '0, 1'b1, 1'b0, PH_IDLE, target, reply_buf[1],
                         {reply_buf[5], reply_buf[4], reply_buf[3], reply_buf[2]});
                    return;
                  end
                end
              end else if (elapsed > gap_limit) set_fault(ERR_BYTE_TO);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      emit(KIND_STATUS, '0, 1'b1, 1'b0, phase, '0, '0, '0);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $realtime, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, actual kind %0d tx %02h phase %0d",
                 $realtime, got.kind, got.tx_byte, got.bus_phase);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      compare("last", 32'(want.last), 32'(got.last));
      compare("accepted", 32'(want.accepted), 32'(got.accepted));
      compare("error_code", 32'(want.error_code), 32'(got.error_code));
      compare("bus_phase", 32'(want.bus_phase), 32'(got.bus_phase));
      compare("reply_module", 32'(want.reply_module), 32'(got.reply_module));
      compare("reply_command", 32'(want.reply_command), 32'(got.reply_command));
      compare("reply_value", want.reply_value, got.reply_value);
    endfunction
  endclass

endpackage

### bench/tb.sv
// Top-level bench for the serial bus master: stimulus, result port, config writes and watchdog.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;
  import sbm_bench_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all before giving up
  localparam int HOLD_CYCLES   = 300;   // long result-side hold-off that backs the block up
  localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES  = 16;    // watch for stray results at the end
  localparam int PHASE_ITEMS   = 120;   // random requests per phase

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  func;
  logic [7:0]  rx_byte;
  logic [7:0]  target_module;
  logic [7:0]  message_id;
  logic [7:0]  command;
  logic [31:0] parameter_req;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        accepted;
  logic [2:0]  error_code;
  logic [2:0]  bus_phase;
  logic [7:0]  reply_module;
  logic [7:0]  reply_command;
  logic [31:0] reply_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  bus_master_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx = 1'b0;
  int unsigned items_sent;
  int unsigned idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  serial_bus_master_request_reply DUT (.*);

  // Result side: check the head at each edge where it is taken, then decide
  // whether to take the next one. The hold flag freezes popping entirely.
  always @(posedge clk) begin : result_port
    res_t got;
    if (!rst && pop && !empty) begin
      got = {kind, tx_byte, last, accepted, error_code, bus_phase,
             reply_module, reply_command, reply_value};
      sb.check_result(got);
    end
    pop <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic int cap(int v, int m);
    return (v < m) ? v : m;
  endfunction

  // Fill every field with random content, then fix the item kind
  function automatic bus_item_t item_of(logic [1:0] f);
    bus_item_t it;
    it.func          = f;
    it.rx_byte       = 8'($urandom());
    it.target_module = 8'($urandom());
    it.message_id    = 8'($urandom());
    it.command       = 8'($urandom());
    it.parameter_req = $urandom();
    return it;
  endfunction

  // Offer one request; return at the edge that accepts it. Push stays high so
  // the next request can follow back to back unless a gap is drawn.
  task automatic offer(bus_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    {func, rx_byte, target_module, message_id, command, parameter_req} <= it;
    do @(posedge clk); while (full);
    sb.take_request(it);
    if (it.func != FN_UNUSED) items_sent++;
  endtask

  task automatic tick(int n);
    repeat (n) offer(item_of(FN_TICK));
  endtask

  task automatic rx(logic [7:0] b);
    bus_item_t it;
    it = item_of(FN_BYTE);
    it.rx_byte = b;
    offer(it);
  endtask

  task automatic request(logic [7:0] id);
    bus_item_t it;
    it = item_of(FN_SEND);
    it.message_id = id;
    offer(it);
  endtask

  // Drop an unused-kind item or a refused request into a busy exchange now and then
  task automatic noise();
    if ($urandom_range(9) != 0) return;
    offer(item_of($urandom_range(1) ? FN_UNUSED : FN_SEND));
  endtask

  // Stop offering and wait for every outstanding result to be popped
  task automatic drain();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, val);
  endtask

  // Registers change only with the block drained; finish with a write to an
  // index past the last register, which must be ignored.
  task automatic configure(logic [15:0] rec, logic [15:0] st, logic [15:0] gap,
                           logic [15:0] endw);
    drain();
    write_reg(REG_RECOVERY, rec);
    write_reg(REG_START_TO, st);
    write_reg(REG_BYTE_TO, gap);
    write_reg(REG_END_WAIT, endw);
    write_reg(8'($urandom_range(255, int'(REG_END_WAIT) + 1)), 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Tick until the bus is idle again; bounded so a huge recovery time cannot hang here
  task automatic settle();
    int n;
    n = 0;
    while (sb.phase != PH_IDLE && n < 100) begin
      tick(1);
      n++;
    end
  endtask

  // One request/reply exchange. pick chooses the outcome:
  //   below 66 clean reply, 66..71 corrupted byte, 72..76 wrong id echoed,
  //   77..79 one byte too many, 80..84 reply stops short, 85..89 bad start byte,
  //   90..94 no reply at all, 95 and up a stray byte on the idle bus first.
  task automatic exchange(int pick);
    logic [7:0]  id;
    logic [7:0]  reply [8];
    logic [15:0] crc;
    int          n_bytes;
    logic [7:0]  b;
    settle();
    if (pick >= 95) begin
      rx(8'($urandom()));
      settle();
    end
    id = 8'($urandom());
    request(id);
    noise();
    if (pick >= 90 && pick < 95) begin
      tick(sb.start_limit + 1);
      return;
    end
    tick($urandom_range(cap(sb.start_limit, 3)));
    if (pick >= 85 && pick < 90) begin
      b = 8'($urandom());
      if (b == ACK_MARK) b = ~b;
      rx(b);
      return;
    end
    rx(ACK_MARK);

    // Build the reply frame: id, command, status LSB first, CRC low then high
    reply[0] = (pick >= 72 && pick < 77) ? id ^ 8'($urandom_range(255, 1)) : id;
    for (int i = 1; i < 6; i++) reply[i] = 8'($urandom());
    crc = crc_ccitt16({reply[5], reply[4], reply[3], reply[2], reply[1], reply[0]});
    reply[6] = crc[7:0];
    reply[7] = crc[15:8];
    if (pick >= 66 && pick < 72) reply[$urandom_range(7)] ^= 8'($urandom_range(255, 1));

    n_bytes = (pick >= 80 && pick < 85) ? $urandom_range(7) : 8;
    for (int i = 0; i < n_bytes; i++) begin
      rx(reply[i]);
      if (i < 7) begin
        tick($urandom_range(cap(sb.gap_limit, 2)));
        noise();
      end
    end
    if (n_bytes < 8) begin
      tick(sb.gap_limit + 1);
      return;
    end
    if (pick >= 77 && pick < 80) begin
      rx(8'($urandom()));
      return;
    end
    // Quiet time expires on this many ticks and the reply gets parsed
    tick(sb.end_wait + 1);
  endtask

  // Random phase with short timeouts so every path is reached in few ticks
  task automatic run_phase(int unsigned s_pct, int unsigned r_pct);
    int unsigned goal;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    configure(16'($urandom_range(6)), 16'($urandom_range(6)),
              16'($urandom_range(4)), 16'($urandom_range(6)));
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) exchange($urandom_range(99));
  endtask

  // Hold off popping for a long stretch in a process of its own
  task automatic hold_results();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
  endtask

  initial begin
    bus_item_t it;
    sb = new();
    rst           <= 1'b1;
    push          <= 1'b0;
    func          <= FN_TICK;
    rx_byte       <= '0;
    target_module <= '0;
    message_id    <= '0;
    command       <= '0;
    parameter_req <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    send_idle_pct = 10;
    recv_idle_pct <= 57;
    items_sent    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset timeouts first, then every register at zero
    tick(1);
    it = '1;
    it.func = FN_UNUSED;
    offer(it);                  // unused kind: status only
    it = '0;
    it.func = FN_SEND;
    offer(it);                  // all-zero request is accepted on the idle bus
    tick(1);                    // reset start timeout is long, so still waiting
    configure('0, '0, '0, '0);
    it = '1;
    it.func = FN_SEND;
    offer(it);                  // refused while waiting for a reply
    tick(1);                    // start timeout
    rx(8'hFF);                  // byte during recovery restarts it
    tick(1);                    // recovery ends, error stays recorded
    rx(8'h00);                  // byte on an idle bus
    tick(1);
    offer(it);                  // all-ones request
    rx(8'h00);                  // reply that does not open with the ack mark
    tick(1);
    request(8'($urandom()));
    rx(ACK_MARK);
    rx(8'($urandom()));
    tick(2);                    // gap timeout in a partial reply, then back to idle
    exchange(0);                // clean reply delivered

    // Random phases: sender idles lightly first, then the receiver, then neither
    run_phase(10, 57);
    run_phase(57, 10);

    // Extremes: every limit at its maximum, so nothing times out; an overlong
    // reply parks the bus in recovery until the next phase shortens it
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    configure('1, '1, '1, '1);
    exchange(78);
    tick(3);

    // Unthrottled phase starting under a long result hold-off
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    configure(16'($urandom_range(6)), 16'($urandom_range(6)),
              16'($urandom_range(4)), 16'($urandom_range(6)));
    hold_results();
    begin : last_phase
      int unsigned goal;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) exchange($urandom_range(99));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
